[rtl/core/scalar_kalman_filter_assert.svh]
// ----------------------------------------------------------------------------
// Scalar Kalman filter assertion macros
// Concurrent assertion shorthands for the filter top, which carries the checks.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scalar_kalman_filter: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scalar_kalman_filter: next-cycle check failed");

`endif

[rtl/core/skf_pkg.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Shared types and constants for the filter front end, back end and top.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_PROCESS_NOISE      = 2'd0,
    REG_MEASUREMENT_NOISE  = 2'd1,
    REG_INITIAL_COVARIANCE = 2'd2,
    REG_INITIAL_ESTIMATE   = 2'd3
  } reg_index_t;

  localparam logic [31:0]        RST_PROCESS_NOISE      = 32'd655;
  localparam logic [31:0]        RST_MEASUREMENT_NOISE  = 32'd65536;
  localparam logic [31:0]        RST_INITIAL_COVARIANCE = 32'd65536;
  localparam logic signed [31:0] RST_INITIAL_ESTIMATE   = 32'sd0;

  typedef struct packed {
    logic [31:0]        process_noise;
    logic [31:0]        measurement_noise;
    logic [31:0]        initial_covariance;
    logic signed [31:0] initial_estimate;
    logic               reload;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] measurement;
  } queue_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_stat_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRED = 6'b000010,
    S_DIV  = 6'b000100,
    S_MULE = 6'b001000,
    S_MULP = 6'b010000,
    S_DONE = 6'b100000
  } back_state_t;

endpackage

`default_nettype wire

[rtl/core/skf_stream_if.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman filter stream interfaces
// Valid/ready channels for measurement words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_meas_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] estimate;
  logic [16:0]        gain;
  logic [31:0]        covariance;

  modport source (output valid, output estimate, output gain, output covariance,
                  input ready);
  modport sink   (input valid, input estimate, input gain, input covariance,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/skf_front.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman filter front end
// Accepts measurement words and holds them in a two-entry queue for the
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_front (
  input  wire logic         clk,
  input  wire logic         rst,
  skf_meas_if.sink          sample,
  output skf_pkg::queue_t   q,
  input  wire logic         pop
);

  localparam int          DEPTH = 2;
  localparam logic [1:0]  FULL  = 2'(DEPTH);

  logic signed [31:0] slot [DEPTH];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  logic               take;

  assign sample.ready  = (count != FULL);
  assign push          = sample.valid && sample.ready;
  assign take          = pop && (count != 2'd0);
  assign q.valid       = (count != 2'd0);
  assign q.measurement = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      priority case ({push, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= sample.measurement;
    end
  end

endmodule

`default_nettype wire

[rtl/core/skf_back.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman filter back end
// Runs one filter step per queued measurement: prediction, restoring gain
// division, and two multiplies through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire skf_pkg::cfg_t    cfg,
  input  wire skf_pkg::queue_t  q,
  output logic                  pop,
  skf_result_if.source          result,
  output skf_pkg::back_stat_t   stat
);

  localparam int GW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + 34;
  localparam int CW = $clog2(FRAC_BITS + 1);

  localparam logic [GW-1:0] ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0] HALF    = {{34{1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  localparam logic [CW-1:0] CNT_TOP = CW'(FRAC_BITS);

  skf_pkg::back_state_t state;

  logic signed [31:0] meas;
  logic signed [31:0] estimate_reg;
  logic [31:0]        covariance_reg;
  logic [31:0]        pp;
  logic [32:0]        den;
  logic               den_zero;
  logic [33:0]        rem;
  logic [GW-1:0]      quo;
  logic [CW-1:0]      cnt;
  logic               first;
  logic [32:0]        mag;
  logic               neg;
  logic [GW-1:0]      gain_r;
  logic [PW-1:0]      prod;

  logic               res_valid;
  logic signed [31:0] res_estimate;
  logic [16:0]        res_gain;
  logic [31:0]        res_covariance;

  logic [32:0]        pp_sum;
  logic [31:0]        pp_sat;
  logic signed [32:0] diff;
  logic [33:0]        trial;
  logic               fits;
  logic [GW-1:0]      gain_eff;
  logic [32:0]        mul_a;
  logic [GW-1:0]      mul_b;
  logic [PW-1:0]      step_sum;
  logic [33:0]        step;
  logic [33:0]        est_ext;
  logic [33:0]        estimate_next;
  logic               out_free;

  assign pop       = (state == skf_pkg::S_IDLE) && q.valid;
  assign stat.busy = (state != skf_pkg::S_IDLE);
  assign stat.pop  = pop;

  assign result.valid      = res_valid;
  assign result.estimate   = res_estimate;
  assign result.gain       = res_gain;
  assign result.covariance = res_covariance;
  assign out_free          = !res_valid || result.ready;

  always_comb begin
    pp_sum   = {1'b0, covariance_reg} + {1'b0, cfg.process_noise};
    pp_sat   = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
    diff     = {meas[31], meas} - {estimate_reg[31], estimate_reg};
    trial    = first ? rem : {rem[32:0], 1'b0};
    fits     = (trial >= {1'b0, den});
    gain_eff = den_zero ? '0 : quo;
    step_sum = prod + HALF;
    step     = step_sum[PW-1:FRAC_BITS];
    est_ext  = {{2{estimate_reg[31]}}, estimate_reg};
    estimate_next = neg ? (est_ext - step) : (est_ext + step);
    if (state == skf_pkg::S_MULE) begin
      mul_a = mag;
      mul_b = gain_eff;
    end else begin
      mul_a = {1'b0, pp};
      mul_b = ONE - gain_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= skf_pkg::S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (state == skf_pkg::S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        skf_pkg::S_IDLE: begin
          if (q.valid) begin
            state <= skf_pkg::S_PRED;
          end
        end
        skf_pkg::S_PRED: state <= skf_pkg::S_DIV;
        skf_pkg::S_DIV: begin
          if (cnt == '0) begin
            state <= skf_pkg::S_MULE;
          end
        end
        skf_pkg::S_MULE: state <= skf_pkg::S_MULP;
        skf_pkg::S_MULP: state <= skf_pkg::S_DONE;
        skf_pkg::S_DONE: begin
          if (out_free) begin
            state <= skf_pkg::S_IDLE;
          end
        end
        default: state <= skf_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      estimate_reg   <= skf_pkg::RST_INITIAL_ESTIMATE;
      covariance_reg <= skf_pkg::RST_INITIAL_COVARIANCE;
    end else if (cfg.reload) begin
      estimate_reg   <= cfg.initial_estimate;
      covariance_reg <= cfg.initial_covariance;
    end else begin
      if (state == skf_pkg::S_MULP) begin
        estimate_reg <= estimate_next[31:0];
      end
      if (state == skf_pkg::S_DONE && out_free) begin
        covariance_reg <= prod[FRAC_BITS+31:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      skf_pkg::S_IDLE: begin
        meas <= q.measurement;
      end
      skf_pkg::S_PRED: begin
        pp       <= pp_sat;
        den      <= {1'b0, pp_sat} + {1'b0, cfg.measurement_noise};
        den_zero <= (pp_sat == 32'd0) && (cfg.measurement_noise == 32'd0);
        rem      <= {2'b00, pp_sat};
        quo      <= '0;
        cnt      <= CNT_TOP;
        first    <= 1'b1;
        neg      <= diff[32];
        mag      <= diff[32] ? 33'(-diff) : 33'(diff);
      end
      skf_pkg::S_DIV: begin
        rem   <= fits ? (trial - {1'b0, den}) : trial;
        quo   <= {quo[GW-2:0], fits};
        cnt   <= cnt - CW'(1);
        first <= 1'b0;
      end
      skf_pkg::S_MULE: begin
        gain_r <= gain_eff;
        prod   <= PW'(mul_a * mul_b);
      end
      skf_pkg::S_MULP: begin
        prod <= PW'(mul_a * mul_b);
      end
      skf_pkg::S_DONE: begin
        if (out_free) begin
          res_estimate   <= estimate_reg;
          res_gain       <= 17'(gain_r);
          res_covariance <= prod[FRAC_BITS+31:FRAC_BITS];
        end
      end
      default: begin
        meas <= meas;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/scalar_kalman_filter.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// First-order fixed point Kalman filter for one sensor stream.
// ----------------------------------------------------------------------------
// Measurement words enter on the sample channel and one result word per
// measurement leaves on the result channel, both valid/ready. Each result
// carries the new estimate, the gain used and the updated covariance.
// The restoring divider that forms the gain retires one quotient bit per
// cycle, and the two multiplies share one multiplier. The back end handles
// one measurement at a time and pops the next queued word only once the
// last step has handed its result to the result register.
// A two-entry queue in front takes up to two words while a step runs, and
// a result register lets the next step start while a result waits. When the
// receiver stalls, the back end holds its finished step until the result
// register frees up, and the queue then fills and drops sample ready.
// Reset loads the registers with their defaults and the filter state with
// the initial estimate and covariance. Any register write over the APB port
// reloads the state from the initial registers; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scalar_kalman_filter_assert.svh"

module scalar_kalman_filter #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  skf_meas_if.sink                          sample,
  skf_result_if.source                      result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [skf_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [skf_pkg::DATA_W-1:0]   pwdata,
  output logic      [skf_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  skf_pkg::cfg_t       cfg;
  skf_pkg::queue_t     q;
  skf_pkg::back_stat_t stat;
  skf_pkg::reg_index_t reg_index;

  logic               pop;
  logic               wr;
  logic [31:0]        process_noise;
  logic [31:0]        measurement_noise;
  logic [31:0]        initial_covariance;
  logic signed [31:0] initial_estimate;
  logic               reload;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite && pready;
  assign reg_index = skf_pkg::reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise      <= skf_pkg::RST_PROCESS_NOISE;
      measurement_noise  <= skf_pkg::RST_MEASUREMENT_NOISE;
      initial_covariance <= skf_pkg::RST_INITIAL_COVARIANCE;
      initial_estimate   <= skf_pkg::RST_INITIAL_ESTIMATE;
      reload             <= 1'b0;
    end else begin
      reload <= wr;
      if (wr) begin
        unique case (reg_index)
          skf_pkg::REG_PROCESS_NOISE:      process_noise      <= pwdata;
          skf_pkg::REG_MEASUREMENT_NOISE:  measurement_noise  <= pwdata;
          skf_pkg::REG_INITIAL_COVARIANCE: initial_covariance <= pwdata;
          skf_pkg::REG_INITIAL_ESTIMATE:   initial_estimate   <= pwdata;
          default:                         reload             <= 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_index)
      skf_pkg::REG_PROCESS_NOISE:      prdata = process_noise;
      skf_pkg::REG_MEASUREMENT_NOISE:  prdata = measurement_noise;
      skf_pkg::REG_INITIAL_COVARIANCE: prdata = initial_covariance;
      skf_pkg::REG_INITIAL_ESTIMATE:   prdata = initial_estimate;
      default:                         prdata = '0;
    endcase
  end

  assign cfg.process_noise      = process_noise;
  assign cfg.measurement_noise  = measurement_noise;
  assign cfg.initial_covariance = initial_covariance;
  assign cfg.initial_estimate   = initial_estimate;
  assign cfg.reload             = reload;

  skf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .q      (q),
    .pop    (pop)
  );

  skf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q      (q),
    .pop    (pop),
    .result (result),
    .stat   (stat)
  );

  `SKF_ASSERT_NEXT(a_pop_starts_step, clk, rst, stat.pop, stat.busy)
  `SKF_ASSERT_SAME(a_result_from_step, clk, rst, $rose(result.valid), $past(stat.busy))
  `SKF_ASSERT_SAME(a_pop_needs_word, clk, rst, stat.pop, q.valid && !$past(stat.pop))

endmodule

`default_nettype wire
